FILE: rtl/core/dckf_pkg.sv
// Package for the day clock keyframe interpolator: types, constants, keyframe ROM.
// No dependencies.
`default_nettype none
package dckf_pkg;

  localparam int unsigned KeyframeCountDef = 9;
  localparam int unsigned RomDepth = 16;
  localparam int unsigned HourW = 21;
  localparam logic [HourW-1:0] DayQ16 = 21'd1572864;
  localparam int unsigned NumVal = 8;

  // Operation codes
  localparam logic [1:0] OpAdvance = 2'd0;
  localparam logic [1:0] OpSet     = 2'd1;
  localparam logic [1:0] OpSkip    = 2'd2;

  // Register indexes
  localparam logic [0:0] RegSph    = 1'd0;
  localparam logic [0:0] RegPaused = 1'd1;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StFind,
    StLerp,
    StDone
  } state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;      // latch the item
    logic div_step;  // one restoring divide step
    logic apply;     // update clock from the item
    logic find_step; // test one segment
    logic lerp_mul;  // multiply for the current value
    logic lerp_div;  // one divide step of the rounding quotient
    logic lerp_done; // store the current value
    logic out_load;  // capture the result
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic div_last;
    logic find_hit;
    logic find_last;
    logic lerp_last_step;
    logic lerp_last_val;
    logic want_lerp;
  } dp_sts_t;

  // Keyframe ROM: hour, angle, amb rgb, sun rgb, intensity
  function automatic logic [HourW-1:0] key_hour(input logic [3:0] i);
    case (i)
      4'd0: return 21'd0;
      4'd1: return 21'd327680;
      4'd2: return 21'd458752;
      4'd3: return 21'd655360;
      4'd4: return 21'd786432;
      4'd5: return 21'd983040;
      4'd6: return 21'd1179648;
      4'd7: return 21'd1310720;
      4'd8: return 21'd1572864;
      default: return '0;
    endcase
  endfunction

  function automatic logic [14:0] key_val(input logic [3:0] i, input logic [2:0] k);
    logic [14:0] r [0:7];
    case (i)
      4'd0: r = '{15'd11520, 15'd82, 15'd82, 15'd205, 15'd819, 15'd819, 15'd1638, 15'd205};
      4'd1: r = '{15'd8640, 15'd205, 15'd164, 15'd328, 15'd1229, 15'd819, 15'd1229, 15'd410};
      4'd2: r = '{15'd5760, 15'd614, 15'd492, 15'd410, 15'd4096, 15'd2458, 15'd1638,
                  15'd1638};
      4'd3: r = '{15'd2880, 15'd614, 15'd614, 15'd614, 15'd4096, 15'd3891, 15'd3686,
                  15'd2867};
      4'd4: r = '{15'd0, 15'd819, 15'd819, 15'd819, 15'd4096, 15'd4096, 15'd3891, 15'd3277};
      4'd5: r = '{15'd20160, 15'd737, 15'd696, 15'd614, 15'd4096, 15'd3891, 15'd3482,
                  15'd2867};
      4'd6: r = '{15'd17280, 15'd614, 15'd410, 15'd328, 15'd4096, 15'd2048, 15'd1229,
                  15'd2048};
      4'd7: r = '{15'd14400, 15'd328, 15'd246, 15'd410, 15'd1638, 15'd1229, 15'd2048,
                  15'd819};
      4'd8: r = '{15'd11520, 15'd82, 15'd82, 15'd205, 15'd819, 15'd819, 15'd1638, 15'd410};
      default: r = '{default: 15'd0};
    endcase
    return r[k];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/day_clock_keyframe_interpolator.sv
// Each item runs the elapsed-time divide and the clock update; a lit advance then
// searches the segments and interpolates eight values, each by a multiply, a
// restoring divide and a store. One item at a time; the next beat is taken in the
// cycle after the result is loaded, also while that result waits. Reset:
// asynchronous active low; clock, registers and control cleared. Depends on
// dckf_pkg, dckf_ctrl, dckf_datapath.
`default_nettype none
module day_clock_keyframe_interpolator #(
  parameter int unsigned KeyframeCount = dckf_pkg::KeyframeCountDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        op_i,
  input  wire logic [23:0]       elapsed_time_i,
  input  wire logic signed [21:0] hour_value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   lighting_valid_o,
  output logic [14:0]            sun_angle_o,
  output logic [12:0]            ambient_red_o,
  output logic [12:0]            ambient_green_o,
  output logic [12:0]            ambient_blue_o,
  output logic [12:0]            sun_red_o,
  output logic [12:0]            sun_green_o,
  output logic [12:0]            sun_blue_o,
  output logic [12:0]            sun_intensity_o,
  output logic [4:0]             clock_hours_o,
  output logic [5:0]             clock_minutes_o
);
  import dckf_pkg::*;

  logic [23:0] sph_q;
  logic        paused_q;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sph_q    <= '0;
      paused_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (paddr[2])
        RegSph:    sph_q    <= pwdata[23:0];
        RegPaused: paused_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      RegSph:    prdata = {8'd0, sph_q};
      RegPaused: prdata = {31'd0, paused_q};
      default:   prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  dckf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  dckf_datapath #(.KeyframeCount(KeyframeCount)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .op_i, .elapsed_time_i, .hour_value_i,
    .sph_i(sph_q), .paused_i(paused_q),
    .lighting_valid_o, .sun_angle_o, .ambient_red_o, .ambient_green_o,
    .ambient_blue_o, .sun_red_o, .sun_green_o, .sun_blue_o, .sun_intensity_o,
    .clock_hours_o, .clock_minutes_o
  );
endmodule
`default_nettype wire

FILE: rtl/core/dckf_datapath.sv
// Datapath: clock register, serial divider, segment search, interpolation.
// Depends on dckf_pkg.
`default_nettype none
module dckf_datapath #(
  parameter int unsigned KeyframeCount = dckf_pkg::KeyframeCountDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dckf_pkg::dp_cmd_t   cmd_i,
  output dckf_pkg::dp_sts_t        sts_o,
  input  wire logic [1:0]          op_i,
  input  wire logic [23:0]         elapsed_time_i,
  input  wire logic signed [21:0]  hour_value_i,
  input  wire logic [23:0]         sph_i,
  input  wire logic                paused_i,
  output logic                     lighting_valid_o,
  output logic [14:0]              sun_angle_o,
  output logic [12:0]              ambient_red_o,
  output logic [12:0]              ambient_green_o,
  output logic [12:0]              ambient_blue_o,
  output logic [12:0]              sun_red_o,
  output logic [12:0]              sun_green_o,
  output logic [12:0]              sun_blue_o,
  output logic [12:0]              sun_intensity_o,
  output logic [4:0]               clock_hours_o,
  output logic [5:0]               clock_minutes_o
);
  import dckf_pkg::*;

  localparam int unsigned DivW = 32;   // dividend dt<<8
  localparam int unsigned LDivW = 37;  // |num| + span/2 fits 37 bits
  localparam logic [3:0] LastSeg = 4'(KeyframeCount - 2);
  localparam logic signed [23:0] DayS  = 24'sd1572864;
  localparam logic signed [23:0] Day2S = 24'sd3145728;

  logic [HourW-1:0] hour_q, hour_d;
  logic [1:0]       op_q;
  logic             pause_q;
  logic             zero_q;
  logic signed [21:0] hv_q;

  // shared restoring divider
  logic [LDivW-1:0] quo_q, quo_d;
  logic [LDivW:0]   rem_q, rem_d;
  logic [LDivW-1:0] dvs_q, dvs_d;
  logic [5:0]       cnt_q, cnt_d;

  logic [3:0]  seg_q, seg_d;
  logic [2:0]  vidx_q, vidx_d;
  logic        neg_q, neg_d;
  logic [14:0] va_q;
  logic [14:0] vals_q [NumVal];

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      pause_q <= paused_i;
      zero_q  <= (sph_i == '0);
      hv_q    <= hour_value_i;
    end
  end

  // segment bounds
  logic [HourW-1:0] h0, h1, span, off;
  assign h0   = key_hour(seg_q);
  assign h1   = key_hour(seg_q + 4'd1);
  assign span = h1 - h0;
  assign off  = hour_q - h0;

  // signed difference times offset, one multiplier
  logic signed [15:0] diff;
  logic signed [37:0] prod;
  logic [36:0]        mag;
  assign diff = signed'({1'b0, key_val(seg_q + 4'd1, vidx_q)})
              - signed'({1'b0, key_val(seg_q, vidx_q)});
  assign prod = diff * signed'({1'b0, off});
  assign mag  = prod[37] ? 37'(-prod) : prod[36:0];

  // divider step
  logic [LDivW:0] rem_sh, rem_sub;
  assign rem_sh  = {rem_q[LDivW-1:0], quo_q[LDivW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  // steps run while the count is nonzero; at zero the quotient is complete
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      quo_d = LDivW'({elapsed_time_i, 8'd0}) << (LDivW - DivW);
      rem_d = '0;
      dvs_d = LDivW'(sph_i);
      cnt_d = 6'(DivW);
    end else if (cmd_i.lerp_mul) begin
      quo_d = mag + LDivW'(span >> 1);
      rem_d = '0;
      dvs_d = LDivW'(span);
      cnt_d = 6'(LDivW);
    end else if ((cmd_i.div_step || cmd_i.lerp_div) && cnt_q != '0) begin
      if (!rem_sub[LDivW]) begin
        rem_d = rem_sub;
        quo_d = {quo_q[LDivW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[LDivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    cnt_q <= cnt_d;
  end

  // clock update
  logic [HourW-1:0] inc;
  logic [HourW:0]   sum;
  logic signed [23:0] sk, wr;
  always_comb begin
    inc = (quo_q > LDivW'(DayQ16 - 1'b1)) ? DayQ16 - 1'b1 : quo_q[HourW-1:0];
    sum = {1'b0, hour_q} + {1'b0, inc};
    if (op_q == OpSet) sk = 24'(hv_q);
    else sk = 24'(hv_q) + signed'({3'b0, hour_q});
    // sk lies in [-2^21, 24h + 2^21): up to two adds or subtracts of 24h
    if (sk < -DayS) wr = sk + Day2S;
    else if (sk < 0) wr = sk + DayS;
    else if (sk >= Day2S) wr = sk - Day2S;
    else if (sk >= DayS) wr = sk - DayS;
    else wr = sk;
    hour_d = hour_q;
    case (op_q)
      OpAdvance: if (!pause_q && !zero_q)
                   hour_d = (sum >= {1'b0, DayQ16}) ? 21'(sum - {1'b0, DayQ16}) : sum[20:0];
      OpSet, OpSkip: hour_d = wr[HourW-1:0];
      default: hour_d = hour_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hour_q <= '0;
    else if (cmd_i.apply) hour_q <= hour_d;
  end

  // search and lerp sequencing
  logic hit;
  assign hit = (hour_q >= h0) && (hour_q < h1);

  always_comb begin
    seg_d  = seg_q;
    vidx_d = vidx_q;
    neg_d  = neg_q;
    if (cmd_i.apply) seg_d = '0;
    else if (cmd_i.find_step) begin
      if (hit) seg_d = seg_q;
      else if (seg_q == LastSeg) seg_d = '0;
      else seg_d = seg_q + 4'd1;
    end
    if (cmd_i.apply) vidx_d = '0;
    else if (cmd_i.lerp_done) vidx_d = vidx_q + 3'd1;
    if (cmd_i.lerp_mul) neg_d = prod[37];
  end

  always_ff @(posedge clk_i) begin
    seg_q  <= seg_d;
    vidx_q <= vidx_d;
    neg_q  <= neg_d;
    if (cmd_i.lerp_mul) va_q <= key_val(seg_q, vidx_q);
  end

  // result of one value, clamped
  logic signed [38:0] v;
  logic [14:0] vc, vmax;
  always_comb begin
    vmax = (vidx_q == 3'd0) ? 15'd23040 : 15'd4096;
    if (span == '0) v = 39'(va_q);
    else if (neg_q) v = 39'(va_q) - signed'({2'b0, quo_q});
    else v = 39'(va_q) + signed'({2'b0, quo_q});
    if (v < 0) vc = '0;
    else if (v > signed'(39'(vmax))) vc = vmax;
    else vc = v[14:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lerp_done) vals_q[vidx_q] <= vc;
  end

  // result register
  logic want;
  assign want = (op_q == OpAdvance) && !pause_q;
  logic [21:0] mins;
  assign mins = 22'(({6'd0, hour_q[15:0]} * 22'd60) >> 16);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      lighting_valid_o <= want;
      sun_angle_o      <= want ? vals_q[0] : '0;
      ambient_red_o    <= want ? vals_q[1][12:0] : '0;
      ambient_green_o  <= want ? vals_q[2][12:0] : '0;
      ambient_blue_o   <= want ? vals_q[3][12:0] : '0;
      sun_red_o        <= want ? vals_q[4][12:0] : '0;
      sun_green_o      <= want ? vals_q[5][12:0] : '0;
      sun_blue_o       <= want ? vals_q[6][12:0] : '0;
      sun_intensity_o  <= want ? vals_q[7][12:0] : '0;
      clock_hours_o    <= hour_q[20:16];
      clock_minutes_o  <= mins[5:0];
    end
  end

  assign sts_o.div_last       = (cnt_q == '0);
  assign sts_o.find_hit       = hit;
  assign sts_o.find_last      = (seg_q == LastSeg);
  assign sts_o.lerp_last_step = (cnt_q == '0);
  assign sts_o.lerp_last_val  = (vidx_q == 3'(NumVal - 1));
  assign sts_o.want_lerp      = want;
endmodule
`default_nettype wire

FILE: rtl/core/dckf_ctrl.sv
// Controller FSM: sequences divide, clock update, search and interpolation.
// Depends on dckf_pkg.
`default_nettype none
module dckf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire dckf_pkg::dp_sts_t sts_i,
  output dckf_pkg::dp_cmd_t      cmd_o
);
  import dckf_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   mul_q, mul_d; // lerp phase: 1 = multiply pending

  // next state
  always_comb begin
    state_d = state_q;
    mul_d   = mul_q;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StDiv;
      StDiv: if (sts_i.div_last) state_d = StFind;
      StFind: begin
        if (!sts_i.want_lerp) state_d = StDone;
        else if (sts_i.find_hit || sts_i.find_last) begin
          state_d = StLerp;
          mul_d = 1'b1;
        end
      end
      StLerp: begin
        if (mul_q) mul_d = 1'b0;
        else if (sts_i.lerp_last_step) begin
          mul_d = 1'b1;
          if (sts_i.lerp_last_val) state_d = StDone;
        end
      end
      StDone: if (!ov_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    in_ready_o = (state_q == StIdle);
    case (state_q)
      StIdle: cmd_o.load = in_valid_i;
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cmd_o.apply = sts_i.div_last;
      end
      StFind: cmd_o.find_step = 1'b1;
      StLerp: begin
        cmd_o.lerp_mul  = mul_q;
        cmd_o.lerp_div  = !mul_q;
        cmd_o.lerp_done = !mul_q && sts_i.lerp_last_step;
      end
      StDone: cmd_o.out_load = !ov_q || out_ready_i;
      default: cmd_o = '0;
    endcase
    ov_d = ov_q;
    if (out_ready_i) ov_d = 1'b0;
    if (cmd_o.out_load) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
      mul_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      mul_q   <= mul_d;
    end
  end

  assign out_valid_o = ov_q;
endmodule
`default_nettype wire

FILE: rtl/core/dckf_checker.sv
// Port-level checker for the day clock interpolator, bound to the top level.
// No package dependency.
`default_nettype none
module dckf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       lighting_valid_o,
  input wire logic [4:0] clock_hours_o,
  input wire logic [5:0] clock_minutes_o,
  input wire logic [14:0] sun_angle_o
);
  // a held result keeps its clock fields
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(clock_hours_o) && $stable(clock_minutes_o))
    else $error("result changed while stalled");
  // clock fields stay in range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> clock_hours_o < 5'd24 && clock_minutes_o < 6'd60)
    else $error("clock out of range");
  // no lighting means zero angle
  a_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !lighting_valid_o |-> sun_angle_o == '0)
    else $error("angle without lighting");
  // an accepted item is not followed by another the next cycle
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted back to back");
endmodule

bind day_clock_keyframe_interpolator dckf_checker u_chk (.*);
`default_nettype wire

FILE: dv/tb.sv
// Testbench for day_clock_keyframe_interpolator: directed and random items with a
// scoreboard that predicts clock and lighting results. Depends on dckf_pkg and the RTL.
`default_nettype none
module tb;
  import dckf_pkg::*;

  localparam longint Day = 1572864;
  localparam int unsigned WatchLimit = 20000;
  localparam logic [2:0] AddrSph    = 3'd0;
  localparam logic [2:0] AddrPaused = 3'd4;
  localparam logic [1:0] OpUnused   = 2'd3;

  // Keyframe table for prediction: hour then eight values
  function automatic longint kf(int i, int k);
    longint t [0:8][0:8] = '{
      '{0, 11520, 82, 82, 205, 819, 819, 1638, 205},
      '{327680, 8640, 205, 164, 328, 1229, 819, 1229, 410},
      '{458752, 5760, 614, 492, 410, 4096, 2458, 1638, 1638},
      '{655360, 2880, 614, 614, 614, 4096, 3891, 3686, 2867},
      '{786432, 0, 819, 819, 819, 4096, 4096, 3891, 3277},
      '{983040, 20160, 737, 696, 614, 4096, 3891, 3482, 2867},
      '{1179648, 17280, 614, 410, 328, 4096, 2048, 1229, 2048},
      '{1310720, 14400, 328, 246, 410, 1638, 1229, 2048, 819},
      '{1572864, 11520, 82, 82, 205, 819, 819, 1638, 410}};
    return t[i][k];
  endfunction

  typedef struct packed {
    logic        lit;
    logic [14:0] angle;
    logic [12:0] ar, ag, ab, sr, sg, sb, si;
    logic [4:0]  hh;
    logic [5:0]  mm;
  } sky_t;

  class sky_scoreboard;
    logic [20:0] hour;
    logic [23:0] sph;
    logic        paused;
    sky_t        pending[$];
    int          errors;
    int          matched;

    function new();
      hour = '0; sph = '0; paused = 1'b0; errors = 0; matched = 0;
    endfunction

    function automatic longint blend(longint a, longint b, longint off, longint span);
      longint num, q;
      if (span <= 0) return a;
      num = (b - a) * off;
      if (num >= 0) q = (num + span / 2) / span;
      else q = -((-num + span / 2) / span);
      return a + q;
    endfunction

    function void note_item(logic [1:0] op, logic [23:0] dt, logic signed [21:0] hv);
      sky_t   r;
      longint inc, s, v, lim;
      int     seg;
      r = '0;
      if (op == OpAdvance && !paused) begin
        if (sph != 0) begin
          inc = (longint'(dt) << 8) / longint'(sph);
          if (inc > Day - 1) inc = Day - 1;
          s = longint'(hour) + inc;
          if (s >= Day) s -= Day;
          hour = s[20:0];
        end
        seg = 0;
        for (int i = 0; i < 8; i++)
          if (hour >= kf(i, 0) && hour < kf(i + 1, 0)) begin seg = i; break; end
        r.lit = 1'b1;
        for (int k = 1; k <= 8; k++) begin
          v = blend(kf(seg, k), kf(seg + 1, k), longint'(hour) - kf(seg, 0),
                    kf(seg + 1, 0) - kf(seg, 0));
          lim = (k == 1) ? 23040 : 4096;
          if (v < 0) v = 0;
          if (v > lim) v = lim;
          case (k)
            1: r.angle = v[14:0];
            2: r.ar = v[12:0];
            3: r.ag = v[12:0];
            4: r.ab = v[12:0];
            5: r.sr = v[12:0];
            6: r.sg = v[12:0];
            7: r.sb = v[12:0];
            default: r.si = v[12:0];
          endcase
        end
      end else if (op == OpSet || op == OpSkip) begin
        s = (op == OpSet) ? longint'(hv) : longint'(hour) + longint'(hv);
        s = s % Day;
        if (s < 0) s += Day;
        hour = s[20:0];
      end
      r.hh = hour[20:16];
      inc = (longint'(hour[15:0]) * 60) >>> 16;
      r.mm = inc[5:0];
      pending.push_back(r);
    endfunction

    function void check_result(sky_t got);
      sky_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp lit=%0d ang=%0d amb=%0d/%0d/%0d sun=%0d/%0d/%0d int=%0d %0d:%0d",
                   e.lit, e.angle, e.ar, e.ag, e.ab, e.sr, e.sg, e.sb, e.si, e.hh, e.mm,
                   "\n          got lit=%0d ang=%0d amb=%0d/%0d/%0d sun=%0d/%0d/%0d int=%0d %0d:%0d",
                   got.lit, got.angle, got.ar, got.ag, got.ab, got.sr, got.sg, got.sb,
                   got.si, got.hh, got.mm);
      end else matched++;
    endfunction
  endclass

  logic clk = 1'b0, rst_n = 1'b0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [1:0] op = '0;
  logic [23:0] dt = '0;
  logic signed [21:0] hv = '0;
  sky_t res;
  sky_scoreboard sb = new();
  int watch = 0, items = 0, n_adv = 0, n_lit = 0;
  bit stall_long = 0;

  always #6 clk = ~clk;

  day_clock_keyframe_interpolator dut (
    .clk_i(clk), .rst_ni(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .op_i(op), .elapsed_time_i(dt),
    .hour_value_i(hv), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .lighting_valid_o(res.lit), .sun_angle_o(res.angle), .ambient_red_o(res.ar),
    .ambient_green_o(res.ag), .ambient_blue_o(res.ab), .sun_red_o(res.sr),
    .sun_green_o(res.sg), .sun_blue_o(res.sb), .sun_intensity_o(res.si),
    .clock_hours_o(res.hh), .clock_minutes_o(res.mm));

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  // Sample accepted beats and run the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_item(op, dt, hv);
        items++;
        if (op == OpAdvance) n_adv++;
      end
      if (out_valid && out_ready) begin
        if (res.lit) n_lit++;
        sb.check_result(res);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (sb.pending.size() == 0 && !in_valid))
        watch <= 0;
      else watch <= watch + 1;
      if (watch >= WatchLimit) begin
        $display("watchdog expired");
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side back-pressure
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (stall_long) out_ready <= 1'b1;
      else begin
        g = gap_len();
        if (g > 4) begin
          out_ready <= 1'b0;
          repeat (g) @(negedge clk);
          out_ready <= 1'b1;
        end else out_ready <= (g == 0) || ($urandom_range(0, 3) != 0 && g < 4);
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    if (addr == AddrSph) sb.sph = data[23:0];
    else sb.paused = data[0];
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send(logic [1:0] o, logic [23:0] d, logic signed [21:0] h, bit gaps);
    int g;
    if (gaps) begin
      g = gap_len();
      repeat (g) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1; op <= o; dt <= d; hv <= h;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic send_random();
    int c;
    logic [1:0] o;
    c = $urandom_range(0, 19);
    o = (c < 13) ? OpAdvance : (c < 16) ? OpSet : (c < 19) ? OpSkip : OpUnused;
    send(o, (c & 1) ? 24'($urandom()) : 24'($urandom_range(0, 4096)),
         ($urandom_range(0, 1)) ? 22'($urandom()) :
         22'(int'($urandom_range(0, 3145726)) - 1572863), 1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // Zero rate: advance keeps clock but still lights
    send(OpAdvance, 24'hFFFFFF, '0, 0);
    drain();
    reg_write(AddrSph, 32'd256);
    send(OpAdvance, 24'd0, '0, 0);
    send(OpAdvance, 24'hFFFFFF, '0, 0); // saturated increment
    send(OpSet, 24'h3FFFFF, 22'sd1572863, 0);
    send(OpSet, '0, -22'sd1572863, 0);
    send(OpSet, '0, 22'sh1FFFFF, 0);
    send(OpSet, '0, -22'sh200000, 0);
    send(OpSkip, '0, 22'sd1572863, 0);
    send(OpSkip, '0, 22'sh1FFFFF, 0);
    send(OpSkip, '0, -22'sd1, 0);
    send(OpUnused, 24'h123456, 22'sd5, 0);
    // Keyframe boundaries
    for (int i = 0; i < 8; i++) begin
      send(OpSet, '0, 22'(kf(i, 0)), 0);
      send(OpAdvance, '0, '0, 0);
    end
    send(OpSet, '0, 22'sd1572863, 0);
    send(OpAdvance, 24'd1, '0, 0); // wrap past midnight
    drain();
    reg_write(AddrPaused, 32'd1);
    send(OpAdvance, 24'd5000, '0, 0);
    send(OpSkip, '0, 22'sd70000, 0);
    drain();
    // Random phases over several rate settings
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(AddrPaused, {31'd0, ph == 5});
      case (ph)
        0: reg_write(AddrSph, 32'hFFFFFF);
        1: reg_write(AddrSph, 32'd1);
        2: reg_write(AddrSph, 32'd0);
        default: reg_write(AddrSph, $urandom_range(1, 65536));
      endcase
      for (int n = 0; n < 100; n++) begin
        if (ph == 3 && n == 50) begin
          stall_long = 1;
          while (sb.pending.size() != 0) @(posedge clk);
          stall_long = 0;
        end
        send_random();
      end
      drain();
    end
    $display("run: %0d items, %0d advances, %0d lit results, %0d matched", items, n_adv,
             n_lit, sb.matched);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
